@@ rtl/ipcsum_pkg.sv @@
// Shared types, constants and the one's-complement adder for the checksum unit.
package ipcsum_pkg;

  // Region kinds
  localparam logic [1:0] KIND_IP  = 2'd0;
  localparam logic [1:0] KIND_UDP = 2'd1;
  localparam logic [1:0] KIND_TCP = 2'd2;

  // Protocol numbers added as part of the pseudo-header
  localparam logic [15:0] PROTO_UDP = 16'd17;
  localparam logic [15:0] PROTO_TCP = 16'd6;

  // Address bytes carried in the stream, subtracted from the length term
  localparam logic [15:0] HDR_ADDR_BYTES = 16'd8;

  // Byte counter saturation point
  localparam logic [15:0] MAX_BYTES = 16'hffff;

  // One input request, as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       last_byte;
  } item_t;

  // One result request
  typedef struct packed {
    logic [15:0] checksum_value;
    logic        short_packet;
  } res_t;

  // Four-operand one's-complement sum with end-around carry.
  // The result is zero only when every operand is zero, matching a chain of
  // two-operand end-around adds.
  function automatic logic [15:0] ocsum4(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] c, input logic [15:0] d);
    logic [17:0] s;
    logic [16:0] f1;
    logic [16:0] f2;
    s  = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
    f1 = {1'b0, s[15:0]} + {15'd0, s[17:16]};
    f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return f2[15:0];
  endfunction

endpackage

@@ rtl/ipcsum_acc.sv @@
// Running sum, byte pairing and byte count; forms the checksum on the last byte.
module ipcsum_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ipcsum_pkg::item_t   item,
  output ipcsum_pkg::res_t    res
);
  import ipcsum_pkg::*;

  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  high_byte_hold_r, high_byte_hold_nxt;
  logic        odd_phase_r, odd_phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;

  logic [15:0] count;
  logic [15:0] word;
  logic [15:0] proto;
  logic [15:0] len_term;
  logic        is_l4;
  logic        shrt;
  logic [15:0] final_sum;

  // Saturating count including the current byte
  assign count = (byte_count_r < MAX_BYTES) ? byte_count_r + 16'd1 : byte_count_r;

  // Word completed by this byte; a lone trailing byte is padded low
  assign word = odd_phase_r ? {high_byte_hold_r, item.data_byte} : {item.data_byte, 8'h00};

  // Partial pseudo-header
  assign is_l4    = (item.kind == KIND_UDP) || (item.kind == KIND_TCP);
  assign shrt     = is_l4 && (count < HDR_ADDR_BYTES);
  assign proto    = !is_l4 ? 16'd0 : ((item.kind == KIND_UDP) ? PROTO_UDP : PROTO_TCP);
  assign len_term = is_l4 ? count - HDR_ADDR_BYTES : 16'd0;

  assign final_sum          = ocsum4(running_sum_r, word, proto, len_term);
  assign res.short_packet   = shrt;
  assign res.checksum_value = shrt ? 16'd0 : ~final_sum;

  // Next state
  always_comb begin
    running_sum_nxt    = running_sum_r;
    high_byte_hold_nxt = high_byte_hold_r;
    odd_phase_nxt      = odd_phase_r;
    byte_count_nxt     = byte_count_r;
    if (step) begin
      if (item.last_byte) begin
        running_sum_nxt    = 16'd0;
        high_byte_hold_nxt = 8'd0;
        odd_phase_nxt      = 1'b0;
        byte_count_nxt     = 16'd0;
      end else begin
        byte_count_nxt = count;
        if (!odd_phase_r) begin
          high_byte_hold_nxt = item.data_byte;
          odd_phase_nxt      = 1'b1;
        end else begin
          running_sum_nxt    = ocsum4(running_sum_r, word, 16'd0, 16'd0);
          high_byte_hold_nxt = 8'd0;
          odd_phase_nxt      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r    <= 16'd0;
      high_byte_hold_r <= 8'd0;
      odd_phase_r      <= 1'b0;
      byte_count_r     <= 16'd0;
    end else begin
      running_sum_r    <= running_sum_nxt;
      high_byte_hold_r <= high_byte_hold_nxt;
      odd_phase_r      <= odd_phase_nxt;
      byte_count_r     <= byte_count_nxt;
    end
  end

endmodule

@@ rtl/internet_checksum_pseudo_header_unit.sv @@
// Top level: input register, accumulator and result register of the checksum unit.
//
//  channel  direction  handshake            payload
//  in_      request    in_valid / in_ready  in_data_byte, in_kind, in_last_byte
//  out_     result     out_valid/out_ready  out_checksum_value, out_short_packet
//
// One byte per cycle sustained unless a last byte waits on a held result. A byte is
// registered on accept and folded into the sum as it leaves the input register; for a
// last byte the checksum is loaded into the result register at that same edge.
// rst_n is synchronous and clears the sum, count, pairing phase and both valids.
// A held result only stalls the input when the byte waiting in the input
// register is a last byte; ordinary bytes keep flowing under output stall.
module internet_checksum_pseudo_header_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_kind,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_checksum_value,
  output logic        out_short_packet
);
  import ipcsum_pkg::*;

  logic  s_valid_r;
  item_t s_item_r;
  logic  s_fire;
  logic  out_free;
  res_t  acc_res;
  logic  out_valid_r;
  res_t  out_res_r;

  // Stage advances unless a last byte waits on a full result register that is not being read
  assign out_free = !out_valid_r || out_ready;
  assign s_fire   = s_valid_r && (!s_item_r.last_byte || out_free);
  assign in_ready = !s_valid_r || s_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item_r.data_byte <= in_data_byte;
      s_item_r.kind      <= in_kind;
      s_item_r.last_byte <= in_last_byte;
    end
  end

  ipcsum_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s_fire),
    .item  (s_item_r),
    .res   (acc_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_fire && s_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_item_r.last_byte) begin
      out_res_r <= acc_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_checksum_value = out_res_r.checksum_value;
  assign out_short_packet   = out_res_r.short_packet;

  // Checks
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.short_packet |-> out_res_r.checksum_value == 16'd0)
    else $error("short packet with nonzero checksum");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s_valid_r && s_item_r.last_byte && out_valid_r && !out_ready)
    else $error("input stalled without a blocked last byte");

  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    s_fire && s_item_r.last_byte |=> out_valid_r)
    else $error("last byte did not produce a result");

endmodule

@@ dv/checksum_monitor.sv @@
// Watches both channels, predicts each region's checksum and compares the results.
`timescale 1ns / 1ps

module checksum_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_kind,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_checksum_value,
  input  logic        out_short_packet,
  output int unsigned mismatches,
  output int unsigned open_results
);
  import ipcsum_pkg::*;

  // Checksums predicted for closed regions, oldest first
  res_t        expected_sums[$];

  // Accumulator state of the region in progress
  logic [15:0] region_sum;
  logic [7:0]  pending_hi;
  logic        hi_held;
  logic [15:0] region_bytes;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  always @(posedge clk) begin
    logic [15:0] n;
    logic [15:0] total;
    res_t        want;
    if (!rst_n) begin
      expected_sums.delete();
      region_sum   = '0;
      pending_hi   = '0;
      hi_held      = 1'b0;
      region_bytes = '0;
      mismatches   = 0;
    end else begin
      // Byte request: fold into the running sum, close the region on the last byte
      if (in_valid && in_ready) begin
        n = (region_bytes < MAX_BYTES) ? region_bytes + 16'd1 : region_bytes;
        if (!in_last_byte) begin
          if (!hi_held) begin
            pending_hi = in_data_byte;
            hi_held    = 1'b1;
          end else begin
            region_sum = ones_add(region_sum, {pending_hi, in_data_byte});
            pending_hi = '0;
            hi_held    = 1'b0;
          end
          region_bytes = n;
        end else begin
          // odd trailing byte is padded with a zero low byte
          total = hi_held ? ones_add(region_sum, {pending_hi, in_data_byte})
                          : ones_add(region_sum, {in_data_byte, 8'h00});
          want.short_packet = 1'b0;
          if (in_kind == KIND_UDP || in_kind == KIND_TCP) begin
            if (n < HDR_ADDR_BYTES) begin
              want.short_packet = 1'b1;
            end else begin
              total = ones_add(total, (in_kind == KIND_UDP) ? PROTO_UDP : PROTO_TCP);
              total = ones_add(total, n - HDR_ADDR_BYTES);
            end
          end
          want.checksum_value = want.short_packet ? 16'h0000 : ~total;
          expected_sums.push_back(want);
          region_sum   = '0;
          pending_hi   = '0;
          hi_held      = 1'b0;
          region_bytes = '0;
        end
      end

      // Result request: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result: checksum_value %h short_packet %b",
                 out_checksum_value, out_short_packet);
          mismatches++;
        end else begin
          want = expected_sums.pop_front();
          if (out_checksum_value !== want.checksum_value) begin
            $error("checksum_value: expected %h, got %h",
                   want.checksum_value, out_checksum_value);
            mismatches++;
          end
          if (out_short_packet !== want.short_packet) begin
            $error("short_packet: expected %b, got %b", want.short_packet, out_short_packet);
            mismatches++;
          end
        end
      end
    end
    open_results = expected_sums.size();
  end

endmodule

@@ dv/internet_checksum_pseudo_header_unit_tb.sv @@
// Stimulus, watchdog and verdict for the checksum unit.
`timescale 1ns / 1ps

module internet_checksum_pseudo_header_unit_tb;
  import ipcsum_pkg::*;

  localparam int          IDLE_LIMIT = 5000;
  localparam logic [1:0]  KIND_RSVD  = 2'd3;   // unused code, handled as plain IP

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic [1:0]  in_kind      = KIND_IP;
  logic        in_last_byte = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [15:0] out_checksum_value;
  logic        out_short_packet;

  int          gap_pct   = 0;
  int          stall_pct = 0;
  int unsigned bytes_sent   = 0;
  int unsigned regions_sent = 0;
  int unsigned idle_cycles  = 0;
  int unsigned mismatches;
  int unsigned open_results;

  initial begin
    forever #5 clk = ~clk;
  end

  internet_checksum_pseudo_header_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_kind           (in_kind),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_checksum_value(out_checksum_value),
    .out_short_packet  (out_short_packet)
  );

  checksum_monitor i_monitor (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_kind           (in_kind),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_checksum_value(out_checksum_value),
    .out_short_packet  (out_short_packet),
    .mismatches        (mismatches),
    .open_results      (open_results)
  );

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any request moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte request; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic [1:0] k, input logic l);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_kind      <= k;
    in_last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // A whole region; fill < 0 gives random bytes, mixed_kind varies kind per byte
  task automatic push_region(input logic [1:0] k, input int unsigned len, input int fill,
                             input bit mixed_kind);
    logic [7:0] b;
    logic [1:0] kk;
    for (int unsigned i = 0; i < len; i++) begin
      b  = (fill < 0) ? 8'($urandom) : 8'(fill);
      kk = mixed_kind ? 2'($urandom) : k;
      push_byte(b, kk, i == len - 1);
    end
    regions_sent++;
  endtask

  // Random regions until both the byte and the region goals are met
  task automatic random_phase(input int gap, input int stall, input int unsigned byte_goal,
                              input int unsigned region_goal);
    logic [1:0]  kinds [4];
    int unsigned sel;
    int unsigned len;
    int unsigned idx;
    kinds     = '{KIND_IP, KIND_UDP, KIND_TCP, KIND_RSVD};
    gap_pct   = gap;
    stall_pct = stall;
    while (bytes_sent < byte_goal || regions_sent < region_goal) begin
      sel = $urandom_range(99);
      if (sel < 40)      len = $urandom_range(1, 9);    // around the short-region boundary
      else if (sel < 90) len = $urandom_range(10, 30);
      else               len = $urandom_range(31, 100);
      idx = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
      push_region(kinds[idx], len, -1, $urandom_range(99) < 15);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero byte, all-ones word, short regions, exact minimum, unused kind
    push_region(KIND_IP,   1, 8'h00, 1'b0);
    push_region(KIND_IP,   2, 8'hff, 1'b0);
    push_region(KIND_UDP,  1, -1,    1'b0);
    push_region(KIND_TCP,  8, 8'hff, 1'b0);
    push_region(KIND_RSVD, 3, -1,    1'b0);
    push_region(KIND_UDP,  7, -1,    1'b0);

    // Random phases: no idling, sender gaps, receiver stalls, both
    random_phase(0,  0,  150, 12);
    random_phase(55, 0,  300, 24);
    random_phase(0,  55, 450, 36);
    random_phase(12, 12, 600, 48);
    in_valid <= 1'b0;

    // Drain and let any stray result show up
    while (open_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && open_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ internet_checksum_pseudo_header_unit.f @@
rtl/ipcsum_pkg.sv
rtl/ipcsum_acc.sv
rtl/internet_checksum_pseudo_header_unit.sv
dv/checksum_monitor.sv
dv/internet_checksum_pseudo_header_unit_tb.sv
